// ----- sv/gmrlm_pkg.sv -----
// Shared types and constants for the gain, mute and RMS level meter.
// No dependencies; imported by every module of the block.
`default_nettype none

package gmrlm_pkg;

    // Fixed field widths
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int LEVEL_W   = 7;
    localparam int GAIN_FRAC = 12;
    localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
    localparam int QUOT_W    = PROD_W - GAIN_FRAC;
    localparam int MAG_W     = SAMPLE_W + 1;
    // largest square is 2^30, so 31 bits hold it
    localparam int SQ_W      = 31;

    // Square root: 32-bit radicand, two bits per step
    localparam int RAD_W      = 32;
    localparam int ROOT_W     = 16;
    localparam int SREM_W     = ROOT_W + 2;
    localparam int SQRT_STEPS = RAD_W / 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

    // Level scaling: floor(root / 150) capped at 100.
    // root >= 15000 saturates; below that, root * 27963 >> 22 is exact.
    localparam logic [LEVEL_W-1:0] LVL_MAX       = 7'd100;
    localparam logic [ROOT_W-1:0]  LVL_SAT_ROOT  = 16'd15000;
    localparam int                 LVL_ROOT_W    = 14;
    localparam logic [14:0]        LVL_DIV_MUL   = 15'd27963;
    localparam int                 LVL_DIV_SHIFT = 22;
    localparam int                 LVL_PROD_W    = LVL_ROOT_W + 15;

    localparam int QUEUE_DEPTH = 4;

    // Per-item data handed from the front to the back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] y;
        logic                       last;
        logic                       mute;
    } item_t;

endpackage

`default_nettype wire

// ----- sv/gmrlm_front.sv -----
// Front end: gain multiply, truncate and saturate, square, and block accumulation.
// Depends on gmrlm_pkg.
`default_nettype none

module gmrlm_front #(
    parameter int MAX_BLOCK = 4096,
    localparam int CNT_W = $clog2(MAX_BLOCK + 1),
    localparam int SUM_W = CNT_W + gmrlm_pkg::SQ_W - 1
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [gmrlm_pkg::SAMPLE_W-1:0] s_sample_in,
    input  wire logic                                s_block_end,
    input  wire logic [gmrlm_pkg::GAIN_W-1:0]        gain_i,
    input  wire logic                                mute_i,
    output logic                                     push_valid,
    input  wire logic                                push_ready,
    output gmrlm_pkg::item_t                         push_item,
    output logic [SUM_W-1:0]                         push_sum,
    output logic [CNT_W-1:0]                         push_cnt
);
    import gmrlm_pkg::*;

    // stage A: product
    logic              a_vld_reg;
    logic [PROD_W-1:0] a_prod_reg;
    logic              a_last_reg;
    logic              a_mute_reg;
    // stage B: output sample and its square
    logic                b_vld_reg;
    logic [SAMPLE_W-1:0] b_y_reg;
    logic [SQ_W-1:0]     b_sq_reg;
    logic                b_last_reg;
    logic                b_mute_reg;
    // block accumulators
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic                     a_take, b_take, push_fire, counting;
    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]        biased;
    logic [QUOT_W-1:0]        quot;
    logic [SAMPLE_W-1:0]      y_sat, y_b;
    logic [MAG_W-1:0]         mag;
    logic [2*MAG_W-1:0]       sq_full;
    logic [SUM_W-1:0]         sum_acc;
    logic [CNT_W-1:0]         cnt_acc;

    // pipeline advance
    assign push_fire = push_valid && push_ready;
    assign b_take    = !b_vld_reg || push_ready;
    assign a_take    = !a_vld_reg || b_take;
    assign s_ready   = a_take;

    // signed sample times unsigned Q4.12 gain
    assign prod = s_sample_in * $signed({1'b0, gain_i});

    // truncate toward zero: bias negative products before the shift
    assign biased = a_prod_reg + (a_prod_reg[PROD_W-1] ?
                    PROD_W'((1 << GAIN_FRAC) - 1) : PROD_W'(0));
    assign quot   = biased[PROD_W-1:GAIN_FRAC];

    // saturate to 16 bits when the upper bits are not a sign extension
    always_comb begin
        if (quot[QUOT_W-1:SAMPLE_W-1] == '0 || quot[QUOT_W-1:SAMPLE_W-1] == '1) begin
            y_sat = quot[SAMPLE_W-1:0];
        end else if (quot[QUOT_W-1]) begin
            y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    assign y_b     = a_mute_reg ? '0 : y_sat;
    assign mag     = y_b[SAMPLE_W-1] ? (MAG_W'(0) - {y_b[SAMPLE_W-1], y_b}) : {1'b0, y_b};
    assign sq_full = mag * mag;

    // accumulate the first MAX_BLOCK squares of the block
    assign counting = cnt_reg < CNT_W'(MAX_BLOCK);
    assign sum_acc  = sum_reg + (counting ? SUM_W'(b_sq_reg) : SUM_W'(0));
    assign cnt_acc  = cnt_reg + (counting ? CNT_W'(1) : CNT_W'(0));

    always_comb begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (push_fire) begin
            sum_next = b_last_reg ? '0 : sum_acc;
            cnt_next = b_last_reg ? '0 : cnt_acc;
        end
    end

    assign push_valid     = b_vld_reg;
    assign push_item.y    = $signed(b_y_reg);
    assign push_item.last = b_last_reg;
    assign push_item.mute = b_mute_reg;
    assign push_sum       = sum_acc;
    assign push_cnt       = cnt_acc;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            if (a_take) a_vld_reg <= s_valid;
            if (b_take) b_vld_reg <= a_vld_reg;
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (a_take) begin
            a_prod_reg <= prod;
            a_last_reg <= s_block_end;
            a_mute_reg <= mute_i;
        end
        if (b_take) begin
            b_y_reg    <= y_b;
            b_sq_reg   <= sq_full[SQ_W-1:0];
            b_last_reg <= a_last_reg;
            b_mute_reg <= a_mute_reg;
        end
    end

endmodule

`default_nettype wire

// ----- sv/gmrlm_queue.sv -----
// Short FIFO between the front end and the level back end.
// Depends on gmrlm_pkg.
`default_nettype none

module gmrlm_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push_valid,
    output logic              push_ready,
    input  wire logic [W-1:0] push_data,
    output logic              pop_valid,
    input  wire logic         pop_ready,
    output logic [W-1:0]      pop_data
);
    import gmrlm_pkg::*;

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ----- sv/gmrlm_back.sv -----
// Back end: per-block mean square divide, square root, level scaling and
// the registered result stage. Depends on gmrlm_pkg.
`default_nettype none

module gmrlm_back #(
    parameter int MAX_BLOCK = 4096,
    localparam int CNT_W  = $clog2(MAX_BLOCK + 1),
    localparam int SUM_W  = CNT_W + gmrlm_pkg::SQ_W - 1,
    localparam int STEP_W = $clog2(SUM_W)
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                pop_valid,
    output logic                                     pop_ready,
    input  wire gmrlm_pkg::item_t                    pop_item,
    input  wire logic [SUM_W-1:0]                    pop_sum,
    input  wire logic [CNT_W-1:0]                    pop_cnt,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [gmrlm_pkg::SAMPLE_W-1:0]    m_sample_out,
    output logic [gmrlm_pkg::LEVEL_W-1:0]            m_level,
    output logic                                     m_level_new,
    output logic                                     m_last
);
    import gmrlm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_LVL  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [LEVEL_W-1:0]  held_reg, held_next;
    logic                m_valid_reg, m_valid_next;
    // working registers
    logic [SUM_W-1:0]    div_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    den_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [SREM_W-1:0]   srem_reg;
    logic [SAMPLE_W-1:0] y_reg;
    // result registers
    logic [SAMPLE_W-1:0] m_sample_reg;
    logic [LEVEL_W-1:0]  m_level_reg;
    logic                m_level_new_reg;
    logic                m_last_reg;

    logic                out_free, pop_fire, start_calc, out_load;
    logic [SAMPLE_W-1:0] out_y;
    logic [LEVEL_W-1:0]  out_level;
    logic                out_new;
    logic [CNT_W:0]      rem_sh, rem_diff;
    logic                div_ge;
    logic [CNT_W-1:0]    rem_step;
    logic [SUM_W-1:0]    div_step;
    logic [SREM_W+1:0]   srem_sh, trial, srem_diff;
    logic                sqrt_ge;
    logic [SREM_W-1:0]   srem_step;
    logic [ROOT_W-1:0]   root_step;
    logic [LVL_PROD_W-1:0] lvl_prod;
    logic [LEVEL_W-1:0]  lvl_calc;

    assign out_free   = !m_valid_reg || m_ready;
    assign start_calc = pop_item.last && !pop_item.mute;
    assign pop_ready  = (state_reg == ST_IDLE) && (out_free || start_calc);
    assign pop_fire   = pop_valid && pop_ready;

    // restoring divide, one quotient bit per cycle
    assign rem_sh   = {rem_reg, div_reg[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign div_ge   = rem_sh >= {1'b0, den_reg};
    assign rem_step = div_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    assign div_step = {div_reg[SUM_W-2:0], div_ge};

    // digit-by-digit square root, two radicand bits per cycle
    assign srem_sh   = {srem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign srem_diff = srem_sh - trial;
    assign sqrt_ge   = srem_sh >= trial;
    assign srem_step = sqrt_ge ? srem_diff[SREM_W-1:0] : srem_sh[SREM_W-1:0];
    assign root_step = {root_reg[ROOT_W-2:0], sqrt_ge};

    // level = min(100, root / 150)
    assign lvl_prod = root_reg[LVL_ROOT_W-1:0] * LVL_DIV_MUL;
    assign lvl_calc = (root_reg >= LVL_SAT_ROOT) ? LVL_MAX :
                      LEVEL_W'(lvl_prod >> LVL_DIV_SHIFT);

    // sequencer
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        held_next  = held_reg;
        out_load   = 1'b0;
        out_y      = y_reg;
        out_level  = held_reg;
        out_new    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (pop_fire) begin
                    if (start_calc) begin
                        state_next = ST_DIV;
                        step_next  = '0;
                    end else begin
                        out_load  = 1'b1;
                        out_y     = pop_item.y;
                        out_new   = pop_item.last;
                        out_level = pop_item.last ? '0 : held_reg;
                        held_next = out_level;
                    end
                end
            end
            ST_DIV: begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    state_next = ST_SQRT;
                    step_next  = '0;
                end
            end
            ST_SQRT: begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_LVL;
                    step_next  = '0;
                end
            end
            ST_LVL: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_level  = lvl_calc;
                    out_new    = 1'b1;
                    held_next  = lvl_calc;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (pop_fire && start_calc) begin
            div_reg <= pop_sum;
            den_reg <= pop_cnt;
            rem_reg <= '0;
            y_reg   <= pop_item.y;
        end
        if (state_reg == ST_DIV) begin
            div_reg <= div_step;
            rem_reg <= rem_step;
            // mean square never exceeds 2^30, so the low bits carry it all
            rad_reg  <= RAD_W'(div_step);
            root_reg <= '0;
            srem_reg <= '0;
        end
        if (state_reg == ST_SQRT) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            srem_reg <= srem_step;
            root_reg <= root_step;
        end
        if (out_load) begin
            m_sample_reg    <= out_y;
            m_level_reg     <= out_level;
            m_level_new_reg <= out_new;
            m_last_reg      <= out_new;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = $signed(m_sample_reg);
    assign m_level      = m_level_reg;
    assign m_level_new  = m_level_new_reg;
    assign m_last       = m_last_reg;

endmodule

`default_nettype wire

// ----- sv/gain_mute_rms_level_meter_unit.sv -----
// Ordinary samples pass stage A, stage B, the queue and the result register, one beat per cycle while
// the back end is idle and the result side takes each beat. A block end without mute holds its result
// in the back end for the divide, the square root and the level scaling; the 4-entry queue lets the
// next block keep accumulating.
// Synchronous active-low reset clears sums, counts, held level, gain to unity
// and mute off; no clearing pass.
`default_nettype none

module gain_mute_rms_level_meter_unit #(
    parameter int MAX_BLOCK = 4096
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [gmrlm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [gmrlm_pkg::GAIN_W-1:0]           cfg_wdata,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [gmrlm_pkg::SAMPLE_W-1:0]  s_sample_in,
    input  wire logic                                   s_block_end,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [gmrlm_pkg::SAMPLE_W-1:0]       m_sample_out,
    output logic [gmrlm_pkg::LEVEL_W-1:0]               m_level,
    output logic                                        m_level_new,
    output logic                                        m_last
);
    import gmrlm_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W = CNT_W + SQ_W - 1;
    localparam int Q_W   = $bits(item_t) + SUM_W + CNT_W;

    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic              mute_reg, mute_next;

    logic             push_valid, push_ready, pop_valid, pop_ready;
    item_t            push_item, pop_item;
    logic [SUM_W-1:0] push_sum, pop_sum;
    logic [CNT_W-1:0] push_cnt, pop_cnt;
    logic [Q_W-1:0]   pop_data;

    // configuration registers
    always_comb begin
        gain_next = gain_reg;
        mute_next = mute_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GAIN: gain_next = cfg_wdata;
                CFG_MUTE: mute_next = cfg_wdata[0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
            mute_reg <= 1'b0;
        end else begin
            gain_reg <= gain_next;
            mute_reg <= mute_next;
        end
    end

    gmrlm_front #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_in (s_sample_in),
        .s_block_end (s_block_end),
        .gain_i      (gain_reg),
        .mute_i      (mute_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item),
        .push_sum    (push_sum),
        .push_cnt    (push_cnt)
    );

    gmrlm_queue #(
        .W     (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_item, push_sum, push_cnt}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_item = item_t'(pop_data[Q_W-1 -: $bits(item_t)]);
    assign pop_sum  = pop_data[CNT_W +: SUM_W];
    assign pop_cnt  = pop_data[CNT_W-1:0];

    gmrlm_back #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .pop_sum      (pop_sum),
        .pop_cnt      (pop_cnt),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_level      (m_level),
        .m_level_new  (m_level_new),
        .m_last       (m_last)
    );

`ifndef SYNTH
    // level never leaves its scale
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_level <= LVL_MAX))
        else $error("level above full scale");

    // an updated level only comes with the last beat of a block
    a_new_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_level_new) |-> m_last)
        else $error("level update without block end");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");
`endif

endmodule

`default_nettype wire

// ----- tb/gain_mute_rms_level_meter_unit_tb.sv -----
// Self-checking testbench for gain_mute_rms_level_meter_unit: gain, mute, saturation and
// block RMS level, each result beat checked against an in-bench predictor or a directed table entry.
// Depends on gmrlm_pkg (sv/gmrlm_pkg.sv) and the unit RTL; reads no files.
module gain_mute_rms_level_meter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gmrlm_pkg::*;

    localparam int     MAX_BLOCK    = 4096;
    localparam int     LONG_BLOCK   = 160;
    localparam int     RAND_BEATS   = 970;
    localparam int     NUM_DIR      = 26;
    localparam int     DRAIN_CYCLES = 100;
    localparam int     CYCLE_LIMIT  = 1000000;
    localparam int     IDLE_PCT     = 11;
    localparam longint UNITY_GAIN   = longint'(1) << GAIN_FRAC;
    localparam longint SAMPLE_MAX   = 32767;
    localparam longint SAMPLE_MIN   = -32768;
    localparam longint LEVEL_STEP   = 150;

    // One result beat, field by field
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smp_out;
        logic [LEVEL_W-1:0]         level;
        logic                       level_new;
        logic                       last;
    } meter_result_t;

    typedef enum logic [0:0] {ROW_BEAT, ROW_REG} row_kind_t;

    // One row of the directed table: a sample beat or a register write
    typedef struct packed {
        row_kind_t                  kind;
        logic [CFG_IDX_W-1:0]       reg_idx;
        logic [GAIN_W-1:0]          wdata;
        logic signed [SAMPLE_W-1:0] smp;
        logic                       blk_end;
        logic                       typed;
        meter_result_t              want;
    } stim_row_t;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [GAIN_W-1:0]          cfg_wdata;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in;
    logic                       s_block_end;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_sample_out;
    logic [LEVEL_W-1:0]         m_level;
    logic                       m_level_new;
    logic                       m_last;

    // Predictor state and its copy of the registers
    longint unsigned      sq_sum;
    int unsigned          blk_count;
    logic [LEVEL_W-1:0]   held_lvl;
    logic [GAIN_W-1:0]    cur_gain;
    logic                 cur_mute;

    meter_result_t        due_results [$];
    stim_row_t            dir_tab [NUM_DIR];
    logic                 quiet;
    int                   mismatches;
    int                   results_seen;
    int                   beats_sent;
    int                   blocks_closed;
    int                   settings_used;
    int                   cycles;

    gain_mute_rms_level_meter_unit #(
        .MAX_BLOCK(MAX_BLOCK)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_in (s_sample_in),
        .s_block_end (s_block_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sample_out(m_sample_out),
        .m_level     (m_level),
        .m_level_new (m_level_new),
        .m_last      (m_last)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Run guard
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Floor square root, two bits per step
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned bitv;
        rem  = v;
        res  = 0;
        bitv = longint'(1) << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Gain or mute, saturate, accumulate the square and update the level on a block end
    function automatic meter_result_t scale_and_meter(input logic signed [SAMPLE_W-1:0] smp,
                                                      input logic blk_end);
        longint          scaled;
        longint          mag;
        longint unsigned rms;
        meter_result_t   r;
        if (cur_mute) begin
            scaled = 0;
        end else begin
            // signed divide truncates toward zero
            scaled = (longint'(smp) * longint'({1'b0, cur_gain})) / UNITY_GAIN;
            if (scaled > SAMPLE_MAX) scaled = SAMPLE_MAX;
            if (scaled < SAMPLE_MIN) scaled = SAMPLE_MIN;
        end
        // past MAX_BLOCK samples the sum and count hold
        if (blk_count < MAX_BLOCK) begin
            mag = (scaled < 0) ? -scaled : scaled;
            sq_sum += longint'(mag * mag);
            blk_count++;
        end
        if (blk_end) begin
            if (cur_mute) begin
                held_lvl = '0;
            end else begin
                rms = root_floor(sq_sum / blk_count) / LEVEL_STEP;
                held_lvl = (rms > LVL_MAX) ? LVL_MAX : rms[LEVEL_W-1:0];
            end
            sq_sum    = 0;
            blk_count = 0;
        end
        r.smp_out   = scaled[SAMPLE_W-1:0];
        r.level     = held_lvl;
        r.level_new = blk_end;
        r.last      = blk_end;
        return r;
    endfunction

    // Directed table rows
    function automatic stim_row_t row_beat(input int smp, input logic e);
        stim_row_t r;
        r         = '0;
        r.kind    = ROW_BEAT;
        r.smp     = SAMPLE_W'(smp);
        r.blk_end = e;
        return r;
    endfunction

    function automatic stim_row_t row_chk(input int smp, input logic e, input int out_smp,
                                          input int lvl, input logic lnew);
        stim_row_t r;
        r                = row_beat(smp, e);
        r.typed          = 1'b1;
        r.want.smp_out   = SAMPLE_W'(out_smp);
        r.want.level     = LEVEL_W'(lvl);
        r.want.level_new = lnew;
        r.want.last      = e;
        return r;
    endfunction

    function automatic stim_row_t row_reg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [GAIN_W-1:0] val);
        stim_row_t r;
        r         = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.wdata   = val;
        return r;
    endfunction

    // Random sample, weighted toward the rails and small values
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(7))
            0:       v = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1:       v = SAMPLE_W'($urandom_range(4) - 2);
            2:       v = SAMPLE_W'($urandom_range(511) - 256);
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        logic [GAIN_W-1:0] g;
        case ($urandom_range(7))
            0:       g = '0;
            1:       g = '1;
            2:       g = GAIN_RESET;
            3:       g = GAIN_RESET - GAIN_W'(1);
            4:       g = GAIN_W'($urandom_range(8191, 2048));
            5:       g = GAIN_W'(1);
            default: g = GAIN_W'($urandom);
        endcase
        return g;
    endfunction

    // Present one beat, hold it until taken, then log what it should produce
    task automatic drive_beat(input logic signed [SAMPLE_W-1:0] smp, input logic blk_end,
                              input logic typed, input meter_result_t typed_res);
        meter_result_t pred;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_sample_in = smp;
        s_block_end = blk_end;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = scale_and_meter(smp, blk_end);
        due_results.push_back(typed ? typed_res : pred);
        beats_sent++;
        if (blk_end) blocks_closed++;
        @(negedge aclk);
    endtask

    // Register write, only once every outstanding result has come back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        s_valid = 1'b0;
        while (due_results.size() != 0) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == CFG_GAIN) cur_gain = val;
        else cur_mute = val[0];
    endtask

    // Result side back-pressure
    always @(negedge aclk) begin
        m_ready = quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare each result beat with the oldest outstanding prediction
    always @(posedge aclk) begin : check_beat
        meter_result_t got;
        meter_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_sample_out, m_level, m_level_new, m_last};
            results_seen++;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result beat: sample %0d level %0d new %0b last %0b",
                             $realtime, got.smp_out, got.level, got.level_new, got.last);
            end else begin
                want = due_results.pop_front();
                if (got.smp_out !== want.smp_out || got.level !== want.level ||
                    got.level_new !== want.level_new || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] beat %0d: exp s=%0d l=%0d n=%0b e=%0b, got s=%0d l=%0d n=%0b e=%0b",
                                 $realtime, results_seen, want.smp_out, want.level,
                                 want.level_new, want.last, got.smp_out, got.level,
                                 got.level_new, got.last);
                end
            end
        end
    end

    initial begin
        int               rand_beats;
        int               nblk;
        int               len;
        logic             mute_pick;
        logic signed [SAMPLE_W-1:0] smp;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_GAIN;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_sample_in = '0;
        s_block_end = 1'b0;
        m_ready     = 1'b0;
        quiet       = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        beats_sent    = 0;
        blocks_closed = 0;
        settings_used = 0;
        cycles        = 0;
        rand_beats    = 0;
        sq_sum        = 0;
        blk_count     = 0;
        held_lvl      = '0;
        cur_gain      = GAIN_RESET;
        cur_mute      = 1'b0;

        // Directed part: rails, mute mid-block, gain extremes, truncation toward zero
        dir_tab = '{
            row_chk(0, 1'b1, 0, 0, 1'b1),            // zero block straight after reset
            row_chk(32767, 1'b0, 32767, 0, 1'b0),    // unity gain passes the rail
            row_chk(-32768, 1'b1, -32768, 100, 1'b1),// full-scale block caps the level
            row_chk(1, 1'b0, 1, 100, 1'b0),
            row_chk(-1, 1'b1, -1, 0, 1'b1),
            row_beat(100, 1'b0),                     // block left open across mute
            row_reg(CFG_MUTE, GAIN_W'(1)),
            row_chk(5000, 1'b0, 0, 0, 1'b0),
            row_chk(-5000, 1'b1, 0, 0, 1'b1),        // muted block end forces level 0
            row_beat(7000, 1'b0),                    // muted sample still counted
            row_reg(CFG_MUTE, GAIN_W'(0)),
            row_reg(CFG_GAIN, 16'hFFFF),
            row_beat(7000, 1'b1),                    // positive saturation
            row_beat(-32768, 1'b0),                  // negative saturation
            row_beat(1, 1'b0),
            row_beat(-1, 1'b0),
            row_beat(2, 1'b1),
            row_reg(CFG_GAIN, GAIN_W'(0)),
            row_beat(32767, 1'b0),
            row_chk(-32768, 1'b1, 0, 0, 1'b1),       // zero gain, empty energy
            row_reg(CFG_GAIN, GAIN_W'(2048)),
            row_beat(-3, 1'b0),                      // -1.5 truncates to -1
            row_beat(3, 1'b0),
            row_beat(-32768, 1'b1),
            row_reg(CFG_GAIN, GAIN_RESET),
            row_beat(12345, 1'b0)
        };

        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_REG) begin
                write_reg(dir_tab[i].reg_idx, dir_tab[i].wdata);
                settings_used++;
            end else begin
                drive_beat(dir_tab[i].smp, dir_tab[i].blk_end, dir_tab[i].typed,
                           dir_tab[i].want);
            end
        end

        // Long block with no idling, closing on full-scale samples
        quiet = 1'b1;
        write_reg(CFG_MUTE, '0);
        for (int k = 0; k < LONG_BLOCK; k++) begin
            if (k >= LONG_BLOCK - 4) smp = 16'sh7FFF;
            else smp = SAMPLE_W'($urandom_range(400) - 200);
            drive_beat(smp, k == LONG_BLOCK - 1, 1'b0, '0);
        end

        // Random phases: fresh settings, then a few blocks of random length
        while (rand_beats < RAND_BEATS) begin
            quiet     = ($urandom_range(5) == 0);
            mute_pick = ($urandom_range(4) == 0);
            write_reg(CFG_GAIN, pick_gain());
            write_reg(CFG_MUTE, {{(GAIN_W-1){1'b0}}, mute_pick});
            settings_used++;
            nblk = $urandom_range(6, 1);
            for (int b = 0; b < nblk; b++) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(120, 17) : $urandom_range(16, 1);
                for (int k = 0; k < len; k++) begin
                    drive_beat(pick_sample(), k == len - 1, 1'b0, '0);
                    rand_beats++;
                end
            end
            // sometimes leave a block open into the next setting
            if ($urandom_range(2) == 0) begin
                len = $urandom_range(5, 1);
                for (int k = 0; k < len; k++) begin
                    drive_beat(pick_sample(), 1'b0, 1'b0, '0);
                    rand_beats++;
                end
            end
        end

        // Drain
        s_valid = 1'b0;
        quiet   = 1'b0;
        while (due_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Run covered %0d sample beats in %0d blocks over %0d register settings,",
                 beats_sent, blocks_closed, settings_used);
        $display("including a %0d-sample block; %0d results checked, %0d mismatches.",
                 LONG_BLOCK, results_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/gmrlm_pkg.sv
sv/gmrlm_front.sv
sv/gmrlm_queue.sv
sv/gmrlm_back.sv
sv/gain_mute_rms_level_meter_unit.sv
tb/gain_mute_rms_level_meter_unit_tb.sv
